### hw/rtl/vlsh_pkg.sv
// Package for the variable-length substitution-box hash.
// Holds the shared widths, seeds, trigger values, opcodes and sequencer states.
// No dependencies; imported by every module of the block.
package vlsh_pkg;

   localparam int MAX_DIGEST_BYTES = 32;
   localparam int BYTE_W           = 8;
   localparam int POS_W            = 5;   // index into the digest store
   localparam int CNT_W            = 6;   // position counter and length, holds 0..63
   localparam int OP_W             = 2;

   localparam logic [CNT_W-1:0]  DIGEST_LENGTH_RESET = CNT_W'(20);
   localparam logic [CNT_W-1:0]  DIGEST_LENGTH_MAX   = CNT_W'(MAX_DIGEST_BYTES);

   localparam logic [BYTE_W-1:0] SLOW_A_SEED = 8'd199;
   localparam logic [BYTE_W-1:0] SLOW_B_SEED = 8'd107;
   localparam logic [BYTE_W-1:0] RUN_SEED    = 8'd17;

   // Running-byte values that step the slow counters.
   localparam logic [BYTE_W-1:0] TRIG_A0 = 8'd13;
   localparam logic [BYTE_W-1:0] TRIG_A1 = 8'd101;
   localparam logic [BYTE_W-1:0] TRIG_A2 = 8'd173;
   localparam logic [BYTE_W-1:0] TRIG_A3 = 8'd207;
   localparam logic [BYTE_W-1:0] TRIG_B  = 8'd67;

   typedef enum logic [OP_W-1:0] {
      OP_START  = 2'd0,
      OP_ABSORB = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START_A,
      S_START_B,
      S_START_C,
      S_START_FIN,
      S_ABS_RUN,
      S_ABS_FIN,
      S_READ
   } state_type;

endpackage

### hw/rtl/vlsh_sbox_unit.sv
// Shared byte substitution unit: one lookup into the fixed 256-entry table.
// Depends on vlsh_pkg for the byte width.
module vlsh_sbox_unit (
   input  logic [vlsh_pkg::BYTE_W-1:0] lookup_addr,
   output logic [vlsh_pkg::BYTE_W-1:0] lookup_data
);
   import vlsh_pkg::*;

   localparam logic [BYTE_W-1:0] SBOX [256] = '{
      8'd108, 8'd35,  8'd77,  8'd207, 8'd9,   8'd111, 8'd203, 8'd175,
      8'd70,  8'd142, 8'd194, 8'd252, 8'd115, 8'd141, 8'd32,  8'd182,
      8'd174, 8'd15,  8'd129, 8'd33,  8'd16,  8'd43,  8'd160, 8'd144,
      8'd149, 8'd30,  8'd197, 8'd185, 8'd54,  8'd246, 8'd75,  8'd169,
      8'd103, 8'd66,  8'd57,  8'd240, 8'd23,  8'd68,  8'd244, 8'd232,
      8'd81,  8'd91,  8'd147, 8'd150, 8'd223, 8'd85,  8'd124, 8'd187,
      8'd167, 8'd110, 8'd222, 8'd80,  8'd20,  8'd95,  8'd131, 8'd74,
      8'd242, 8'd65,  8'd49,  8'd11,  8'd139, 8'd64,  8'd181, 8'd2,
      8'd138, 8'd176, 8'd73,  8'd239, 8'd208, 8'd39,  8'd155, 8'd163,
      8'd168, 8'd233, 8'd50,  8'd107, 8'd173, 8'd134, 8'd180, 8'd196,
      8'd0,   8'd69,  8'd121, 8'd82,  8'd132, 8'd17,  8'd42,  8'd212,
      8'd143, 8'd51,  8'd192, 8'd119, 8'd21,  8'd13,  8'd137, 8'd172,
      8'd186, 8'd60,  8'd211, 8'd47,  8'd237, 8'd46,  8'd25,  8'd254,
      8'd53,  8'd195, 8'd198, 8'd3,   8'd250, 8'd71,  8'd227, 8'd213,
      8'd102, 8'd78,  8'd220, 8'd146, 8'd243, 8'd37,  8'd166, 8'd4,
      8'd190, 8'd97,  8'd178, 8'd251, 8'd45,  8'd100, 8'd159, 8'd165,
      8'd219, 8'd34,  8'd116, 8'd22,  8'd202, 8'd179, 8'd157, 8'd38,
      8'd230, 8'd214, 8'd118, 8'd171, 8'd151, 8'd101, 8'd199, 8'd14,
      8'd158, 8'd98,  8'd156, 8'd117, 8'd96,  8'd231, 8'd148, 8'd92,
      8'd12,  8'd130, 8'd161, 8'd206, 8'd218, 8'd113, 8'd193, 8'd245,
      8'd59,  8'd24,  8'd6,   8'd112, 8'd205, 8'd55,  8'd153, 8'd247,
      8'd88,  8'd128, 8'd36,  8'd229, 8'd170, 8'd120, 8'd210, 8'd145,
      8'd209, 8'd26,  8'd8,   8'd200, 8'd221, 8'd177, 8'd67,  8'd89,
      8'd215, 8'd188, 8'd235, 8'd152, 8'd133, 8'd154, 8'd136, 8'd104,
      8'd31,  8'd204, 8'd99,  8'd241, 8'd63,  8'd164, 8'd62,  8'd109,
      8'd1,   8'd248, 8'd191, 8'd106, 8'd140, 8'd84,  8'd226, 8'd189,
      8'd225, 8'd40,  8'd184, 8'd114, 8'd61,  8'd122, 8'd126, 8'd217,
      8'd183, 8'd224, 8'd93,  8'd162, 8'd87,  8'd58,  8'd83,  8'd255,
      8'd10,  8'd105, 8'd76,  8'd28,  8'd201, 8'd7,   8'd56,  8'd52,
      8'd123, 8'd236, 8'd72,  8'd249, 8'd216, 8'd253, 8'd19,  8'd41,
      8'd44,  8'd48,  8'd135, 8'd27,  8'd79,  8'd29,  8'd94,  8'd238,
      8'd5,   8'd18,  8'd228, 8'd127, 8'd125, 8'd86,  8'd234, 8'd90
   };

   assign lookup_data = SBOX[lookup_addr];

endmodule

### hw/rtl/variable_length_sbox_hash.sv
// Variable-length substitution-box hash. Each request word carries an opcode: start clears
// the digest and seeds it in two passes, absorb mixes one data byte through every digest
// byte, read returns the digest one byte per response word with the final byte flagged.
// The digest length register (0 to 32 bytes, values above 32 act as 32) is written through
// csr_wr_en/csr_wr_data and should only change while the block is idle. All work runs
// through a single table lookup unit under a small sequencer, so one request word is taken
// at a time and req_ready stays low until it is done: a start makes three lookups per
// seeded byte and one for the final step, an absorb makes one chained lookup per digest
// byte and one more for the final step, and a read gives one response word per cycle when
// rsp_ready stays high. Unused opcode 3 is accepted and ignored. A response word waits in
// its own output register, so the next request can be accepted while the last digest
// byte is still waiting to be taken.
// Depends on vlsh_pkg and vlsh_sbox_unit.
module variable_length_sbox_hash (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [vlsh_pkg::OP_W-1:0]      req_opcode,
   input  logic [vlsh_pkg::BYTE_W-1:0]    req_data_byte,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [vlsh_pkg::BYTE_W-1:0]    rsp_digest_byte,
   output logic [vlsh_pkg::POS_W-1:0]     rsp_byte_position,
   output logic                           rsp_last_byte,

   input  logic                           csr_wr_en,
   input  logic [vlsh_pkg::CNT_W-1:0]     csr_wr_data
);
   import vlsh_pkg::*;

   // Sequencer state and working registers.
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;       // current digest byte position
   logic                      pass_ff, pass_in;     // second seeding pass
   logic [BYTE_W-1:0]         walk_ff, walk_in;     // fast table walk counter
   logic [BYTE_W-1:0]         slow_a_ff, slow_a_in;
   logic [BYTE_W-1:0]         slow_b_ff, slow_b_in;
   logic [BYTE_W-1:0]         at_ff, at_in;         // lookup address being built
   logic [BYTE_W-1:0]         run_ff, run_in;       // running byte within a command

   // Architectural state.
   logic [BYTE_W-1:0]         chain_ff, chain_in;
   logic [BYTE_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]          len_cfg_ff;
   logic [BYTE_W-1:0]         store_ff [MAX_DIGEST_BYTES];

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic [CNT_W-1:0]          len_act;
   logic [CNT_W-1:0]          pos_inc;
   logic [BYTE_W-1:0]         store_rd;
   logic                      store_clear;
   logic                      store_wr_en;
   logic [BYTE_W-1:0]         store_wr_data;
   logic [BYTE_W-1:0]         lookup_addr;
   logic [BYTE_W-1:0]         lookup_data;
   logic [BYTE_W-1:0]         mix;

   // Lengths above the store size saturate.
   assign len_act  = (len_cfg_ff > DIGEST_LENGTH_MAX) ? DIGEST_LENGTH_MAX : len_cfg_ff;
   assign pos_inc  = pos_ff + CNT_W'(1);
   assign store_rd = store_ff[pos_ff[POS_W-1:0]];

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digest_byte   = rsp_data_ff;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_last_byte     = rsp_last_ff;

   vlsh_sbox_unit u_sbox (
      .lookup_addr (lookup_addr),
      .lookup_data (lookup_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
         count_ff     <= '0;
         len_cfg_ff   <= DIGEST_LENGTH_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         count_ff     <= count_in;
         if (csr_wr_en) begin
            len_cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      pass_ff     <= pass_in;
      walk_ff     <= walk_in;
      slow_a_ff   <= slow_a_in;
      slow_b_ff   <= slow_b_in;
      at_ff       <= at_in;
      run_ff      <= run_in;
      rsp_data_ff <= rsp_data_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digest store: cleared by reset and by a start, written at the current position.
   always_ff @(posedge clock) begin
      if (reset || store_clear) begin
         for (int i = 0; i < MAX_DIGEST_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (store_wr_en) begin
         store_ff[pos_ff[POS_W-1:0]] <= store_wr_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      pass_in       = pass_ff;
      walk_in       = walk_ff;
      slow_a_in     = slow_a_ff;
      slow_b_in     = slow_b_ff;
      at_in         = at_ff;
      run_in        = run_ff;
      chain_in      = chain_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      store_clear   = 1'b0;
      store_wr_en   = 1'b0;
      store_wr_data = run_ff;
      lookup_addr   = run_ff;
      mix           = run_ff ^ lookup_data ^ {{(BYTE_W-CNT_W){1'b0}}, pos_ff} ^ store_rd;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_START: begin
                     store_clear = 1'b1;
                     walk_in     = '0;
                     slow_a_in   = SLOW_A_SEED;
                     slow_b_in   = SLOW_B_SEED;
                     run_in      = RUN_SEED;
                     pass_in     = 1'b0;
                     pos_in      = '0;
                     state_in    = (len_act == '0) ? S_START_FIN : S_START_A;
                  end
                  OP_ABSORB: begin
                     run_in   = chain_ff ^ req_data_byte ^ count_ff;
                     pos_in   = '0;
                     state_in = (len_act == '0) ? S_ABS_FIN : S_ABS_RUN;
                  end
                  OP_READ: begin
                     pos_in   = '0;
                     state_in = (len_act == '0) ? S_IDLE : S_READ;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Seeding: the lookup address is the walk plus two table entries picked by the slow
         // counters, built in S_START_A and S_START_B; S_START_C mixes in the third lookup.
         S_START_A: begin
            lookup_addr = slow_a_ff;
            at_in       = lookup_data;
            state_in    = S_START_B;
         end

         S_START_B: begin
            lookup_addr = slow_b_ff;
            at_in       = walk_ff + at_ff + lookup_data;
            state_in    = S_START_C;
         end

         S_START_C: begin
            lookup_addr   = at_ff;
            run_in        = mix;
            store_wr_en   = 1'b1;
            store_wr_data = mix;
            walk_in       = walk_ff + BYTE_W'(1);
            if (mix == TRIG_A0 || mix == TRIG_A1 || mix == TRIG_A2 || mix == TRIG_A3) begin
               slow_a_in = slow_a_ff + BYTE_W'(1);
            end
            if (mix == TRIG_B) begin
               slow_b_in = slow_b_ff + BYTE_W'(1);
            end
            if (pos_inc < len_act) begin
               pos_in   = pos_inc;
               state_in = S_START_A;
            end else if (!pass_ff) begin
               // The second pass starts at position one.
               pass_in  = 1'b1;
               pos_in   = CNT_W'(1);
               state_in = (len_act > CNT_W'(1)) ? S_START_A : S_START_FIN;
            end else begin
               state_in = S_START_FIN;
            end
         end

         S_START_FIN: begin
            lookup_addr = walk_ff;
            chain_in    = run_ff ^ lookup_data;
            count_in    = '0;
            state_in    = S_IDLE;
         end

         // Absorb: the running byte chains through every digest byte, one lookup each.
         S_ABS_RUN: begin
            lookup_addr   = store_rd ^ run_ff;
            run_in        = lookup_data;
            store_wr_en   = 1'b1;
            store_wr_data = lookup_data;
            pos_in        = pos_inc;
            if (pos_inc == len_act) begin
               state_in = S_ABS_FIN;
            end
         end

         S_ABS_FIN: begin
            lookup_addr = run_ff;
            chain_in    = lookup_data;
            count_in    = count_ff + BYTE_W'(1);
            state_in    = S_IDLE;
         end

         // Readout: load the output register whenever it is empty or being emptied.
         S_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = store_rd;
               rsp_pos_in   = pos_ff[POS_W-1:0];
               rsp_last_in  = (pos_inc == len_act);
               pos_in       = pos_inc;
               if (pos_inc == len_act) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A flagged last word always sits at the final position of the digest.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_pos_ff == POS_W'(len_act - CNT_W'(1))))
      else $error("last digest word not at final position");

   // The readout never runs past the active length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (pos_ff < len_act))
      else $error("readout position beyond digest length");

   // Finishing a start clears the byte count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START_FIN) |=> (count_ff == '0))
      else $error("byte count not cleared by start");

   // The store is only written at a position inside the active digest.
   assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> (pos_ff < len_act))
      else $error("digest store written outside active length");

endmodule
